[rtl/cdg_pkg.sv]
// ----------------------------------------------------------------------------
// cdg_pkg
// Shared widths, register codes, stream packing and the gradient word type
// for the central difference gradient block.
// ----------------------------------------------------------------------------
package cdg_pkg;

  // pixel and result field widths
  localparam int PIXEL_BITS = 12;
  localparam int COL_BITS   = 10;
  localparam int ROW_BITS   = 10;
  localparam int GRAD_BITS  = 13;
  localparam int SQ_BITS    = 25;

  // configuration port
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;

  // smallest frame dimension, and first column/row that yields a result
  localparam int MIN_DIM   = 3;
  localparam int FIRST_OUT = 2;

  // stream packing
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_COL_LSB    = 0;
  localparam int OUT_ROW_LSB    = OUT_COL_LSB + COL_BITS;
  localparam int OUT_GX_LSB     = OUT_ROW_LSB + ROW_BITS;
  localparam int OUT_GY_LSB     = OUT_GX_LSB + GRAD_BITS;
  localparam int OUT_SQ_LSB     = OUT_GY_LSB + GRAD_BITS;
  localparam int OUT_USED_BITS  = OUT_SQ_LSB + SQ_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [COL_BITS-1:0]         col;
    logic [ROW_BITS-1:0]         row;
    logic signed [GRAD_BITS-1:0] gx;
    logic signed [GRAD_BITS-1:0] gy;
    logic                        last;
  } grad_t;

endpackage

[rtl/cdg_ram.sv]
// ----------------------------------------------------------------------------
// cdg_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cdg_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cdg_front.sv]
// ----------------------------------------------------------------------------
// cdg_front
// Position counters, the two line buffers, the pixel window and the central
// differences, ending in a registered gradient word.
// ----------------------------------------------------------------------------
module cdg_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cdg_pkg::CFG_BITS-1:0]  image_width,
  input  logic [cdg_pkg::CFG_BITS-1:0]  image_height,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cdg_pkg::PIXEL_BITS-1:0] in_pixel,
  input  logic                          in_frame_start,
  output logic                          grad_valid,
  input  logic                          grad_ready,
  output cdg_pkg::grad_t                grad
);

  localparam int PB   = cdg_pkg::PIXEL_BITS;
  localparam int GB   = cdg_pkg::GRAD_BITS;
  localparam int CFGB = cdg_pkg::CFG_BITS;
  localparam int COLW = cdg_pkg::COL_BITS;
  localparam int ROWW = cdg_pkg::ROW_BITS;
  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int XNW  = $clog2(MAX_WIDTH + 1);
  localparam int YNW  = $clog2(MAX_HEIGHT + 1);
  localparam int CW   = (CFGB > XNW) ? CFGB : XNW;
  localparam int CH   = (CFGB > YNW) ? CFGB : YNW;

  // clamped frame size
  logic [CW-1:0] w_ext, w;
  logic [CH-1:0] h_ext, h;

  always_comb begin
    w_ext = CW'(image_width);
    h_ext = CH'(image_height);
    if (w_ext < CW'(cdg_pkg::MIN_DIM)) begin
      w = CW'(cdg_pkg::MIN_DIM);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w = CW'(MAX_WIDTH);
    end else begin
      w = w_ext;
    end
    if (h_ext < CH'(cdg_pkg::MIN_DIM)) begin
      h = CH'(cdg_pkg::MIN_DIM);
    end else if (h_ext > CH'(MAX_HEIGHT)) begin
      h = CH'(MAX_HEIGHT);
    end else begin
      h = h_ext;
    end
  end

  // position of the next pixel
  logic [XW-1:0] col_count;
  logic [YW-1:0] row_count;
  logic [XW-1:0] c_in;
  logic [YW-1:0] r_in;
  logic [CW-1:0] c_inc;
  logic [CH-1:0] r_inc;

  // stage one: pixel waiting on its line buffer reads
  logic          s1_valid;
  logic [PB-1:0] s1_pix;
  logic [XW-1:0] s1_c;
  logic [YW-1:0] s1_r;
  logic          s1_byp;
  logic [PB-1:0] s1_byp_prev;
  logic [PB-1:0] s1_byp_prev2;
  logic          s1_hit;
  logic          s1_last;
  logic          s1_adv;
  logic          s2_free;
  logic          accept;
  logic          byp_next;

  logic [PB-1:0] prev_rdata, prev2_rdata;
  logic [PB-1:0] up, top;

  // window: up at c-1, up at c-2, top at c-1, current at c-1
  logic [PB-1:0] win_up1, win_up2, win_top1, win_cur1;

  logic signed [GB-1:0] gx, gy;
  logic [XW-1:0]        c_m1;
  logic [YW-1:0]        r_m1;

  assign c_in  = in_frame_start ? '0 : col_count;
  assign r_in  = in_frame_start ? '0 : row_count;
  assign c_inc = CW'(c_in) + CW'(1);
  assign r_inc = CH'(r_in) + CH'(1);

  assign s2_free  = !grad_valid || grad_ready;
  assign s1_hit   = (CW'(s1_c) >= CW'(cdg_pkg::FIRST_OUT)) && (CW'(s1_c) < w) &&
                    (CH'(s1_r) >= CH'(cdg_pkg::FIRST_OUT)) && (CH'(s1_r) < h);
  assign s1_last  = (CW'(s1_c) == w - CW'(1)) && (CH'(s1_r) == h - CH'(1));
  assign s1_adv   = s1_valid && (!s1_hit || s2_free);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  // a read of the entry that the leaving pixel writes in the same cycle
  assign byp_next = s1_adv && (s1_c == c_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (c_inc >= w) begin
        col_count <= '0;
        if (r_inc >= h) begin
          row_count <= '0;
        end else begin
          row_count <= r_inc[YW-1:0];
        end
      end else begin
        col_count <= c_inc[XW-1:0];
        row_count <= r_in;
      end
    end
  end

  cdg_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (c_in),
    .rdata (prev_rdata)
  );

  cdg_ram #(
    .WIDTH (PB),
    .DEPTH (MAX_WIDTH)
  ) u_line_prev2 (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_c),
    .wdata (up),
    .re    (accept),
    .raddr (c_in),
    .rdata (prev2_rdata)
  );

  assign up  = s1_byp ? s1_byp_prev  : prev_rdata;
  assign top = s1_byp ? s1_byp_prev2 : prev2_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_byp   <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
      s1_byp   <= byp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= in_pixel;
      s1_c         <= c_in;
      s1_r         <= r_in;
      s1_byp_prev  <= s1_pix;
      s1_byp_prev2 <= up;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_up1  <= '0;
      win_up2  <= '0;
      win_top1 <= '0;
      win_cur1 <= '0;
    end else if (s1_adv) begin
      win_up2  <= win_up1;
      win_up1  <= up;
      win_top1 <= top;
      win_cur1 <= s1_pix;
    end
  end

  assign gx   = $signed(GB'(up)) - $signed(GB'(win_up2));
  assign gy   = $signed(GB'(win_cur1)) - $signed(GB'(win_top1));
  assign c_m1 = s1_c - XW'(1);
  assign r_m1 = s1_r - YW'(1);

  // stage two: registered gradient word
  always_ff @(posedge clk) begin
    if (rst) begin
      grad_valid <= 1'b0;
    end else if (s2_free) begin
      grad_valid <= s1_adv && s1_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_adv && s1_hit) begin
      grad.col  <= COLW'(c_m1);
      grad.row  <= ROWW'(r_m1);
      grad.gx   <= gx;
      grad.gy   <= gy;
      grad.last <= s1_last;
    end
  end

endmodule

[rtl/cdg_mag.sv]
// ----------------------------------------------------------------------------
// cdg_mag
// Squared gradient magnitude and the output register of the result stream.
// ----------------------------------------------------------------------------
module cdg_mag (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cdg_pkg::grad_t                     grad,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cdg_pkg::grad_t                     out_grad,
  output logic [cdg_pkg::SQ_BITS-1:0]        out_sq
);

  localparam int GB = cdg_pkg::GRAD_BITS;
  localparam int PW = 2 * GB;

  logic signed [PW-1:0] sq_x, sq_y, sq_sum;

  assign sq_x   = grad.gx * grad.gx;
  assign sq_y   = grad.gy * grad.gy;
  assign sq_sum = sq_x + sq_y;

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_grad <= grad;
      out_sq   <= sq_sum[cdg_pkg::SQ_BITS-1:0];
    end
  end

endmodule

[rtl/central_difference_gradient.sv]
// ----------------------------------------------------------------------------
// central_difference_gradient
// Streamed central difference gradient with squared magnitude over a
// row-major frame of unsigned Q8.4 pixels.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  tdata: pixel, tuser: frame_start
//   m_       out  m_tvalid/m_tready  tdata: col,row,grad_x,grad_y,grad_sq
//                                    tlast: last interior pixel
//   cfg_     in   cfg_we             cfg_index, cfg_data
//
// One pixel is taken every cycle while the output is not stalled; a result
// leaves through the registered line buffer read, the difference register and
// the output register. The line buffers need no clearing after reset.
// A stalled output holds its word while one more result and one pixel
// fill the stages behind it; after that the input stalls.
// ----------------------------------------------------------------------------
module central_difference_gradient #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [cdg_pkg::IN_TDATA_BITS-1:0]     s_tdata,  // pixel[11:0]
  input  logic                                  s_tuser,  // frame_start
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // col[9:0], row[19:10], grad_x[32:20], grad_y[45:33], grad_sq[70:46]
  output logic [cdg_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [cdg_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [cdg_pkg::CFG_BITS-1:0]          cfg_data
);

  logic [cdg_pkg::CFG_BITS-1:0] image_width;
  logic [cdg_pkg::CFG_BITS-1:0] image_height;

  logic                          grad_valid, grad_ready;
  cdg_pkg::grad_t                grad, out_grad;
  logic [cdg_pkg::SQ_BITS-1:0]   out_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= cdg_pkg::WIDTH_RESET;
      image_height <= cdg_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cdg_pkg::cfg_reg_t'(cfg_index))
        cdg_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        cdg_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  cdg_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .image_width    (image_width),
    .image_height   (image_height),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_pixel       (s_tdata[cdg_pkg::PIXEL_BITS-1:0]),
    .in_frame_start (s_tuser),
    .grad_valid     (grad_valid),
    .grad_ready     (grad_ready),
    .grad           (grad)
  );

  cdg_mag u_mag (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (grad_valid),
    .in_ready  (grad_ready),
    .grad      (grad),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_grad  (out_grad),
    .out_sq    (out_sq)
  );

  always_comb begin
    m_tdata = '0;
    m_tdata[cdg_pkg::OUT_COL_LSB +: cdg_pkg::COL_BITS]  = out_grad.col;
    m_tdata[cdg_pkg::OUT_ROW_LSB +: cdg_pkg::ROW_BITS]  = out_grad.row;
    m_tdata[cdg_pkg::OUT_GX_LSB  +: cdg_pkg::GRAD_BITS] = out_grad.gx;
    m_tdata[cdg_pkg::OUT_GY_LSB  +: cdg_pkg::GRAD_BITS] = out_grad.gy;
    m_tdata[cdg_pkg::OUT_SQ_LSB  +: cdg_pkg::SQ_BITS]   = out_sq;
  end

  assign m_tlast = out_grad.last;

endmodule

[rtl/cdg_checker.sv]
// ----------------------------------------------------------------------------
// cdg_checker
// Port level checks on the result stream of the gradient block.
// ----------------------------------------------------------------------------
module cdg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [cdg_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic                               m_tlast
);

  localparam int GB = cdg_pkg::GRAD_BITS;
  localparam int PW = 2 * GB;

  logic signed [GB-1:0]        gx, gy;
  logic [cdg_pkg::SQ_BITS-1:0] sq;
  logic signed [PW-1:0]        sq_ref;

  assign gx     = m_tdata[cdg_pkg::OUT_GX_LSB +: GB];
  assign gy     = m_tdata[cdg_pkg::OUT_GY_LSB +: GB];
  assign sq     = m_tdata[cdg_pkg::OUT_SQ_LSB +: cdg_pkg::SQ_BITS];
  assign sq_ref = gx * gx + gy * gy;

  // a waiting result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // magnitude agrees with the two differences shown beside it
  a_sq_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> sq == sq_ref[cdg_pkg::SQ_BITS-1:0])
    else $error("grad_sq does not match grad_x and grad_y");

  // differences of unsigned pixels never reach the negative limit
  a_grad_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> gx != {1'b1, {(GB-1){1'b0}}} && gy != {1'b1, {(GB-1){1'b0}}})
    else $error("gradient out of range");

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind central_difference_gradient cdg_checker u_cdg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[tb/cdg_checker.sv]
// ----------------------------------------------------------------------------
// tb_cdg_checker
// Watches the pixel, result and register channels of the gradient block,
// keeps its own copy of the line buffers, window and position counters, works
// out the gradient word due for each interior pixel and compares every output
// word field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_cdg_checker #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [cdg_pkg::IN_TDATA_BITS-1:0]  s_tdata,   // pixel[11:0]
  input  logic                               s_tuser,   // frame_start
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // col[9:0], row[19:10], grad_x[32:20], grad_y[45:33], grad_sq[70:46]
  input  logic [cdg_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input  logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [cdg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cdg_pkg::CFG_BITS-1:0]       cfg_data,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB   = cdg_pkg::PIXEL_BITS;
  localparam int COLB = cdg_pkg::COL_BITS;
  localparam int ROWB = cdg_pkg::ROW_BITS;
  localparam int GB   = cdg_pkg::GRAD_BITS;
  localparam int SQB  = cdg_pkg::SQ_BITS;
  localparam int CFGB = cdg_pkg::CFG_BITS;
  localparam int OTB  = cdg_pkg::OUT_TDATA_BITS;
  localparam int FO   = cdg_pkg::FIRST_OUT;

  typedef struct {
    logic [COLB-1:0]      col;
    logic [ROWB-1:0]      row;
    logic signed [GB-1:0] gx;
    logic signed [GB-1:0] gy;
    logic [SQB-1:0]       sq;
    logic                 last;
  } gradient_word_t;

  gradient_word_t grad_due[$];

  logic [PB-1:0] row_above [MAX_WIDTH];
  logic [PB-1:0] row_above2 [MAX_WIDTH];
  // window: row above at c-1 and c-2, two rows above at c-1, current row at c-1
  logic [PB-1:0]   up_c1, up_c2, top_c1, cur_c1;
  logic [CFGB-1:0] width_reg, height_reg;
  int unsigned     col_pos, row_pos;
  int              mismatches = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i]  = '0;
      row_above2[i] = '0;
    end
  end

  function automatic int unsigned frame_dim(input logic [CFGB-1:0] val,
                                            input int unsigned     hi);
    if (val < cdg_pkg::MIN_DIM) return cdg_pkg::MIN_DIM;
    if (val > hi) return hi;
    return val;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic predict_pixel(input logic [PB-1:0] pix, input logic fs);
    int unsigned    w, h;
    logic [PB-1:0]  up, top;
    int             dx, dy;
    gradient_word_t res;
    w = frame_dim(width_reg, MAX_WIDTH);
    h = frame_dim(height_reg, MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    up  = row_above[col_pos];
    top = row_above2[col_pos];
    // result for (c-1, r-1) falls due when (c, r) arrives, inside the frame only
    if (col_pos >= FO && col_pos < w && row_pos >= FO && row_pos < h) begin
      dx = int'(up) - int'(up_c2);
      dy = int'(cur_c1) - int'(top_c1);
      res.col  = COLB'(col_pos - 1);
      res.row  = ROWB'(row_pos - 1);
      res.gx   = GB'(dx);
      res.gy   = GB'(dy);
      res.sq   = SQB'(dx * dx + dy * dy);
      res.last = (col_pos == w - 1) && (row_pos == h - 1);
      grad_due.push_back(res);
    end
    row_above2[col_pos] = up;
    row_above[col_pos]  = pix;
    up_c2  = up_c1;
    up_c1  = up;
    top_c1 = top;
    cur_c1 = pix;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic check_word(input logic [OTB-1:0] word, input logic lst);
    gradient_word_t want;
    if (grad_due.size() == 0) begin
      report_mismatch($sformatf("output word %h with nothing due", word));
      return;
    end
    want = grad_due.pop_front();
    if (word[cdg_pkg::OUT_COL_LSB +: COLB] !== want.col)
      report_mismatch($sformatf("col got %0d want %0d",
                                word[cdg_pkg::OUT_COL_LSB +: COLB], want.col));
    if (word[cdg_pkg::OUT_ROW_LSB +: ROWB] !== want.row)
      report_mismatch($sformatf("row got %0d want %0d at col %0d",
                                word[cdg_pkg::OUT_ROW_LSB +: ROWB], want.row, want.col));
    if (word[cdg_pkg::OUT_GX_LSB +: GB] !== want.gx)
      report_mismatch($sformatf("grad_x got %0d want %0d at (%0d,%0d)",
                                $signed(word[cdg_pkg::OUT_GX_LSB +: GB]), want.gx,
                                want.col, want.row));
    if (word[cdg_pkg::OUT_GY_LSB +: GB] !== want.gy)
      report_mismatch($sformatf("grad_y got %0d want %0d at (%0d,%0d)",
                                $signed(word[cdg_pkg::OUT_GY_LSB +: GB]), want.gy,
                                want.col, want.row));
    if (word[cdg_pkg::OUT_SQ_LSB +: SQB] !== want.sq)
      report_mismatch($sformatf("grad_sq got %0d want %0d at (%0d,%0d)",
                                word[cdg_pkg::OUT_SQ_LSB +: SQB], want.sq,
                                want.col, want.row));
    if (lst !== want.last)
      report_mismatch($sformatf("last got %b want %b at (%0d,%0d)",
                                lst, want.last, want.col, want.row));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      col_pos    = 0;
      row_pos    = 0;
      up_c1      = '0;
      up_c2      = '0;
      top_c1     = '0;
      cur_c1     = '0;
      width_reg  = cdg_pkg::WIDTH_RESET;
      height_reg = cdg_pkg::HEIGHT_RESET;
    end else begin
      if (s_tvalid && s_tready) predict_pixel(s_tdata[PB-1:0], s_tuser);
      if (m_tvalid && m_tready) check_word(m_tdata, m_tlast);
      // a register write takes effect from the next pixel on
      if (cfg_we) begin
        case (cdg_pkg::cfg_reg_t'(cfg_index))
          cdg_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          cdg_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
    end
    errors  <= mismatches;
    pending <= grad_due.size();
  end

endmodule

[tb/tb_central_difference_gradient.sv]
// ----------------------------------------------------------------------------
// tb_central_difference_gradient
// Streams frames of pixels through the gradient block under changing frame
// sizes and random stalls on both sides; the checker beside the block
// predicts and compares every output word.
// ----------------------------------------------------------------------------
module tb_central_difference_gradient;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int PB           = cdg_pkg::PIXEL_BITS;
  localparam int CFGB         = cdg_pkg::CFG_BITS;
  localparam int PAD_BITS     = cdg_pkg::IN_TDATA_BITS - cdg_pkg::PIXEL_BITS;
  localparam int RANDOM_ITEMS = 450;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  logic [cdg_pkg::IN_TDATA_BITS-1:0]  s_tdata   = '0;   // pixel[11:0]
  logic                               s_tuser   = 1'b0; // frame_start
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  // col[9:0], row[19:10], grad_x[32:20], grad_y[45:33], grad_sq[70:46]
  logic [cdg_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic                               m_tlast;
  logic                               cfg_we    = 1'b0;
  logic [cdg_pkg::CFG_IDX_BITS-1:0]   cfg_index = '0;
  logic [CFGB-1:0]                    cfg_data  = '0;

  int   check_errors;
  int   check_pending;
  int   send_idle_pct = 13;
  int   recv_idle_pct = 69;
  logic hold_rx       = 1'b0;
  int   pixels_sent   = 0;
  int   frame_w       = 640;
  int   frame_h       = 480;
  event rx_hold_trigger;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  central_difference_gradient #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tb_cdg_checker #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_grad_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (check_errors),
    .pending   (check_pending)
  );

  // result side
  always @(posedge clk) begin
    m_tready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // long output stall while pixels keep coming, so the block backs up
  initial begin
    @(rx_hold_trigger);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int clamp_dim(input logic [CFGB-1:0] val, input int hi);
    if (val < cdg_pkg::MIN_DIM) return cdg_pkg::MIN_DIM;
    if (val > hi) return hi;
    return val;
  endfunction

  task automatic set_frame(input logic [CFGB-1:0] w_val,
                           input logic [CFGB-1:0] h_val);
    cfg_we    <= 1'b1;
    cfg_index <= cdg_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w_val;
    @(posedge clk);
    cfg_index <= cdg_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h_val;
    @(posedge clk);
    cfg_we  <= 1'b0;
    frame_w = clamp_dim(w_val, MAX_W);
    frame_h = clamp_dim(h_val, MAX_H);
  endtask

  task automatic offer_pixel(input logic [PB-1:0] pix, input logic fs,
                             input logic [PAD_BITS-1:0] pad);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pad, pix};
    s_tuser  <= fs;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_run(input int n, input logic fs_first);
    logic [PB-1:0]       pix;
    logic [PAD_BITS-1:0] pad;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0:       pix = '0;
        1:       pix = '1;
        default: pix = PB'($urandom);
      endcase
      pad = ($urandom_range(19) == 0) ? PAD_BITS'($urandom) : PAD_BITS'(0);
      offer_pixel(pix, fs_first && (i == 0), pad);
    end
    s_tvalid <= 1'b0;
  endtask

  // everything due has left, then a wait for pixels still in the pipe
  task automatic wait_quiet();
    do @(posedge clk); while (check_pending != 0);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [PB-1:0]   pix;
    logic [CFGB-1:0] w_val, h_val;
    int              n_frames, n;
    bit              pressure_done;
    pressure_done = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (!rst);
    @(posedge clk);

    // smallest frame: full positive then full negative differences, with
    // junk in the tdata bits above the pixel
    set_frame(11'd3, 11'd3);
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 9; i++) begin
        if (i == 1 || i == 3) pix = (k == 0) ? '0 : '1;
        else if (i == 5 || i == 7) pix = (k == 0) ? '1 : '0;
        else pix = PB'($urandom);
        offer_pixel(pix, i == 0, PAD_BITS'($urandom));
      end
    end
    s_tvalid <= 1'b0;
    wait_quiet();

    // shrink mid-frame: first the column lies beyond the new width,
    // later the row lies beyond the new height
    set_frame(11'd8, 11'd6);
    send_run(70, 1'b1);
    wait_quiet();
    set_frame(11'd5, 11'd6);
    send_run(39, 1'b0);
    wait_quiet();
    set_frame(11'd4, 11'd3);
    send_run(14, 1'b0);
    wait_quiet();

    pixels_sent = 0;
    while (pixels_sent < RANDOM_ITEMS || !pressure_done) begin
      if (pixels_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 13;
        recv_idle_pct <= 69;
      end else if (pixels_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_idle_pct <= 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      w_val = ($urandom_range(6) == 0) ? CFGB'($urandom_range(2)) :
                                         CFGB'($urandom_range(3, 12));
      h_val = ($urandom_range(6) == 0) ? CFGB'($urandom_range(2)) :
                                         CFGB'($urandom_range(3, 8));
      n_frames = $urandom_range(1, 3);
      if (send_idle_pct == 0 && !pressure_done) begin
        w_val    = 11'd12;
        h_val    = 11'd8;
        n_frames = 2;
      end
      set_frame(w_val, h_val);
      if (send_idle_pct == 0 && !pressure_done) begin
        pressure_done = 1'b1;
        -> rx_hold_trigger;
      end
      for (int f = 0; f < n_frames; f++) begin
        n = frame_w * frame_h;
        // now and then a frame is cut short and the next one may restart it
        if ($urandom_range(5) == 0) n = $urandom_range(1, n - 1);
        send_run(n, (f == 0) || ($urandom_range(3) != 0));
      end
      wait_quiet();
    end

    // sizes above the limit saturate; only the start of each frame is sent
    set_frame(11'd2047, 11'd3);
    send_run(24, 1'b1);
    wait_quiet();
    set_frame(11'd5, 11'd2047);
    send_run(40, 1'b1);
    wait_quiet();

    if (check_errors == 0 && check_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
